### rtl/ffdc_pkg.sv
`timescale 1ns / 1ps

package ffdc_pkg;

    // Store geometry: depth is a power of two so the circular index wraps for free.
    // ADDR_BITS must not exceed SR_BITS (the integer delay carries SR_BITS bits).
    localparam int ADDR_BITS   = 16;
    localparam int STORE_DEPTH = 1 << ADDR_BITS;
    localparam int SAMPLE_BITS = 16;

    localparam int TIME_BITS     = 24;   // smoothed time, Q0.24 seconds
    localparam int FRAC_BITS     = 24;   // fractional part of the read position
    localparam int SR_BITS       = 18;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 18;

    localparam logic signed [16:0] CHORUS_SPAN = 17'sd33554;   // 2 ms in Q0.24
    localparam logic signed [32:0] CHORUS_BASE = 33'sd50332;   // 3 ms in Q0.24
    localparam logic [15:0]        FB_MAX_GAIN = 16'd62259;    // 0.95 in Q0.16

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_DELAY_TIME  = 3'd0,
        CFG_FEEDBACK    = 3'd1,
        CFG_WET_MIX     = 3'd2,
        CFG_MODE        = 3'd3,
        CFG_SAMPLE_RATE = 3'd4,
        CFG_SMOOTHING   = 3'd5
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SMOOTH,
        S_UPDATE,
        S_POS,
        S_ADDR,
        S_RD0,
        S_RD1,
        S_INTERP,
        S_MIX,
        S_OUT
    } state_t;

    typedef struct packed {
        logic                          rd_en;
        logic [ADDR_BITS-1:0]          rd_addr;
        logic                          wr_en;
        logic [ADDR_BITS-1:0]          wr_addr;
        logic signed [SAMPLE_BITS-1:0] wr_data;
    } store_req_t;

    // Clamp to a signed range of the given width.
    function automatic logic signed [47:0] sat_wide(input logic signed [47:0] v,
                                                    input int unsigned bits);
        logic signed [47:0] hi;
        logic signed [47:0] lo;
        hi = (48'sd1 <<< (bits - 1)) - 48'sd1;
        lo = -hi - 48'sd1;
        if (v > hi)
        begin
            sat_wide = hi;
        end
        else if (v < lo)
        begin
            sat_wide = lo;
        end
        else
        begin
            sat_wide = v;
        end
    endfunction

endpackage

### rtl/ffdc_store.sv
`timescale 1ns / 1ps

module ffdc_store (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  ffdc_pkg::store_req_t                    req,
    output logic signed [ffdc_pkg::SAMPLE_BITS-1:0] rd_data
);
    import ffdc_pkg::*;

    logic signed [SAMPLE_BITS-1:0] mem [STORE_DEPTH];
    logic signed [SAMPLE_BITS-1:0] rd_raw_reg;
    logic                          rd_ok_reg;
    logic [ADDR_BITS:0]            fill_reg;   // top bit set once every entry is written
    logic [ADDR_BITS:0]            fill_next;
    logic                          rd_ok_next;

    // Writes land in ascending order from entry zero, so entries below the
    // fill count are live and the rest still read as the reset value zero.
    always_comb
    begin
        rd_ok_next = fill_reg[ADDR_BITS] || ({1'b0, req.rd_addr} < fill_reg);
        fill_next  = fill_reg;
        if (req.wr_en && !fill_reg[ADDR_BITS])
        begin
            fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_raw_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (req.rd_en)
            begin
                rd_ok_reg <= rd_ok_next;
            end
        end
    end

    assign rd_data = rd_ok_reg ? rd_raw_reg : '0;

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.rd_en && req.wr_en))
        else $error("store read and write in the same cycle");

    a_fill_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (req.wr_en && !fill_reg[ADDR_BITS]) |=> fill_reg == $past(fill_reg) + 1'b1)
        else $error("fill count did not follow a write");

    a_fill_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg[ADDR_BITS] |=> fill_reg[ADDR_BITS])
        else $error("full store dropped back to partial fill");

endmodule

### rtl/fractional_feedback_delay_chorus_top.sv
`timescale 1ns / 1ps
// Flow: an accepted input word walks serially through smoother, position multiply,
//   two reads on the single store port, interpolation and mix before audio_out is
//   loaded; a new word is not taken until then, and a pending output word stalls the load.
// Reset: control and config registers, pointer, smoothed time and last read return to reset values;
//   the store is not swept, a fill count makes unwritten entries read as zero.

module fractional_feedback_delay_chorus_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [15:0]                   audio_in,
    input  logic signed [15:0]                   mod_in,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [15:0]                   audio_out,
    input  logic                                 cfg_we,
    input  logic [ffdc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [ffdc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import ffdc_pkg::*;

    localparam int POS_BITS    = TIME_BITS + SR_BITS;
    localparam int FB_BITS     = SAMPLE_BITS + 17;
    localparam int INTERP_BITS = SAMPLE_BITS + FRAC_BITS + 2;
    localparam int MIX_BITS    = ((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16) + 19;

    localparam logic [FRAC_BITS:0]               FRAC_ONE    = (FRAC_BITS + 1)'(1) << FRAC_BITS;
    localparam logic signed [INTERP_BITS-1:0]    INTERP_HALF = INTERP_BITS'(1) << (FRAC_BITS - 1);
    localparam logic signed [MIX_BITS-1:0]       MIX_HALF    = MIX_BITS'(1) << 15;
    localparam logic signed [41:0]               SMOOTH_HALF = 42'sd32768;
    localparam logic signed [FB_BITS-1:0]        FB_HALF     = FB_BITS'(1) << 15;

    // ---------------------------------------------------------------- config
    logic [15:0]         delay_time_reg;
    logic [15:0]         feedback_reg;
    logic [15:0]         wet_reg;
    logic                mode_reg;
    logic [SR_BITS-1:0]  sr_reg;
    logic [15:0]         coeff_reg;
    logic [15:0]         gain_reg;     // 0.95 * feedback_amount, Q0.16
    logic [32:0]         gain_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_time_reg <= '0;
            feedback_reg   <= '0;
            wet_reg        <= '0;
            mode_reg       <= 1'b0;
            sr_reg         <= SR_BITS'(48000);
            coeff_reg      <= 16'd131;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_DELAY_TIME:  delay_time_reg <= cfg_data[15:0];
                CFG_FEEDBACK:    feedback_reg   <= cfg_data[15:0];
                CFG_WET_MIX:     wet_reg        <= cfg_data[15:0];
                CFG_MODE:        mode_reg       <= cfg_data[0];
                CFG_SAMPLE_RATE: sr_reg         <= cfg_data[SR_BITS-1:0];
                CFG_SMOOTHING:   coeff_reg      <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    // Feedback gain is a registered copy of its register; it is first used
    // in the cycle after an accept, so a write just before the word is seen.
    assign gain_full = {17'd0, feedback_reg} * {17'd0, FB_MAX_GAIN} + 33'd32768;

    always_ff @(posedge clk)
    begin
        gain_reg <= gain_full[31:16];
    end

    // ---------------------------------------------------------------- control
    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   out_free;
    logic   out_load;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic [ADDR_BITS-1:0] wp_reg;
    logic [ADDR_BITS-1:0] wp_next;

    store_req_t                    st_req;
    logic signed [SAMPLE_BITS-1:0] st_rd_data;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (accept) state_next = S_SMOOTH;
            S_SMOOTH: state_next = S_UPDATE;
            S_UPDATE: state_next = S_POS;
            S_POS:    state_next = S_ADDR;
            S_ADDR:   state_next = S_RD0;
            S_RD0:    state_next = S_RD1;
            S_RD1:    state_next = S_INTERP;
            S_INTERP: state_next = S_MIX;
            S_MIX:    state_next = S_OUT;
            S_OUT:    if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- datapath
    logic signed [15:0]            audio_reg;
    logic [TIME_BITS-1:0]          target_reg;
    logic [TIME_BITS-1:0]          smooth_reg;
    logic [TIME_BITS-1:0]          smooth_next;
    logic signed [41:0]            smooth_prod_reg;
    logic signed [FB_BITS-1:0]     fb_prod_reg;
    logic signed [SAMPLE_BITS-1:0] wv_reg;
    logic [POS_BITS-1:0]           pos_reg;
    logic [ADDR_BITS-1:0]          idx1_reg;
    logic [FRAC_BITS:0]            w0_reg;
    logic [FRAC_BITS-1:0]          w1_reg;
    logic signed [INTERP_BITS-1:0] p0_reg;
    logic signed [INTERP_BITS-1:0] p1_reg;
    logic signed [SAMPLE_BITS-1:0] readv_reg;
    logic signed [SAMPLE_BITS-1:0] last_read_reg;
    logic signed [MIX_BITS-1:0]    m0_reg;
    logic signed [MIX_BITS-1:0]    m1_reg;
    logic signed [15:0]            audio_out_reg;

    logic signed [32:0]            span_prod;
    logic signed [32:0]            chorus_t;
    logic [TIME_BITS-1:0]          target_c;
    logic signed [TIME_BITS:0]     diff_c;
    logic signed [41:0]            smooth_prod_c;
    logic signed [41:0]            step_c;
    logic signed [FB_BITS-1:0]     fb_prod_c;
    logic signed [FB_BITS-1:0]     fb_c;
    logic signed [47:0]            wv_sat;
    logic [POS_BITS-1:0]           pos_c;
    logic [FRAC_BITS-1:0]          frac_c;
    logic                          frac_nz;
    logic [ADDR_BITS-1:0]          dm_c;
    logic [ADDR_BITS-1:0]          idx1_c;
    logic [ADDR_BITS-1:0]          idx0_c;
    logic [FRAC_BITS:0]            w0_c;
    logic [FRAC_BITS-1:0]          w1_c;
    logic signed [INTERP_BITS-1:0] p0_c;
    logic signed [INTERP_BITS-1:0] p1_c;
    logic signed [INTERP_BITS-1:0] interp_q;
    logic [16:0]                   dry_c;
    logic signed [MIX_BITS-1:0]    m0_c;
    logic signed [MIX_BITS-1:0]    m1_c;
    logic signed [MIX_BITS-1:0]    mix_q;
    logic signed [47:0]            mix_sat;

    always_comb
    begin
        // chorus target: 3 ms + 2 ms * mod, floor of the Q.15 product
        span_prod = mod_in * CHORUS_SPAN;
        chorus_t  = (span_prod >>> 15) + CHORUS_BASE;
        target_c  = mode_reg ? chorus_t[TIME_BITS-1:0] : {delay_time_reg, 8'd0};

        // one-pole smoother, rounded
        diff_c        = $signed({1'b0, target_reg}) - $signed({1'b0, smooth_reg});
        smooth_prod_c = $signed({1'b0, coeff_reg}) * diff_c;
        step_c        = (smooth_prod_reg + SMOOTH_HALF) >>> 16;
        smooth_next   = smooth_reg + step_c[TIME_BITS-1:0];

        // feedback term and saturated store word
        fb_prod_c = last_read_reg * $signed({1'b0, gain_reg});
        fb_c      = (fb_prod_reg + FB_HALF) >>> 16;
        wv_sat    = sat_wide(48'(audio_reg) + 48'(fb_c), SAMPLE_BITS);

        // read position behind the write pointer
        pos_c   = POS_BITS'(smooth_reg) * POS_BITS'(sr_reg);
        frac_c  = pos_reg[FRAC_BITS-1:0];
        frac_nz = |frac_c;
        dm_c    = pos_reg[FRAC_BITS +: ADDR_BITS];
        idx1_c  = wp_reg - dm_c - ADDR_BITS'(frac_nz);
        idx0_c  = idx1_c - ADDR_BITS'(1);
        w0_c    = frac_nz ? {1'b0, frac_c} : FRAC_ONE;
        w1_c    = frac_nz ? FRAC_BITS'(FRAC_ONE - {1'b0, frac_c}) : '0;

        // linear interpolation between the two taps
        p0_c     = st_rd_data * $signed({1'b0, w0_reg});
        p1_c     = st_rd_data * $signed({1'b0, w1_reg});
        interp_q = (p0_reg + p1_reg + INTERP_HALF) >>> FRAC_BITS;

        // wet/dry mix
        dry_c   = 17'h10000 - {1'b0, wet_reg};
        m0_c    = audio_reg * $signed({1'b0, dry_c});
        m1_c    = readv_reg * $signed({1'b0, wet_reg});
        mix_q   = (m0_reg + m1_reg + MIX_HALF) >>> 16;
        mix_sat = sat_wide(48'(mix_q), 16);
    end

    // store port and handshake outputs
    always_comb
    begin
        in_ready       = 1'b0;
        out_load       = 1'b0;
        st_req.rd_en   = 1'b0;
        st_req.rd_addr = idx1_reg;
        st_req.wr_en   = 1'b0;
        st_req.wr_addr = wp_reg;
        st_req.wr_data = wv_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_ADDR:
            begin
                st_req.rd_en   = 1'b1;
                st_req.rd_addr = idx0_c;
            end
            S_RD0:
            begin
                st_req.rd_en = 1'b1;
            end
            S_RD1:
            begin
                st_req.wr_en = 1'b1;   // both taps read; the slot can take the new word
            end
            S_OUT:
            begin
                out_load = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        wp_next        = out_load ? wp_reg + 1'b1 : wp_reg;
        out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            wp_reg        <= '0;
            smooth_reg    <= '0;
            last_read_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            wp_reg        <= wp_next;
            if (state_reg == S_UPDATE)
            begin
                smooth_reg <= smooth_next;
            end
            if (state_reg == S_INTERP)
            begin
                last_read_reg <= interp_q[SAMPLE_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            audio_reg  <= audio_in;
            target_reg <= target_c;
        end
        if (state_reg == S_SMOOTH)
        begin
            smooth_prod_reg <= smooth_prod_c;
            fb_prod_reg     <= fb_prod_c;
        end
        if (state_reg == S_UPDATE)
        begin
            wv_reg <= wv_sat[SAMPLE_BITS-1:0];
        end
        if (state_reg == S_POS)
        begin
            pos_reg <= pos_c;
        end
        if (state_reg == S_ADDR)
        begin
            idx1_reg <= idx1_c;
            w0_reg   <= w0_c;
            w1_reg   <= w1_c;
        end
        if (state_reg == S_RD0)
        begin
            p0_reg <= p0_c;     // older tap, floor-1
        end
        if (state_reg == S_RD1)
        begin
            p1_reg <= p1_c;     // floor tap
        end
        if (state_reg == S_INTERP)
        begin
            readv_reg <= interp_q[SAMPLE_BITS-1:0];
        end
        if (state_reg == S_MIX)
        begin
            m0_reg <= m0_c;
            m1_reg <= m1_c;
        end
        if (out_load)
        begin
            audio_out_reg <= mix_sat[15:0];
        end
    end

    ffdc_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (st_req),
        .rd_data (st_rd_data)
    );

    assign out_valid = out_valid_reg;
    assign audio_out = audio_out_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_SMOOTH)
        else $error("accepted word did not start processing");

    a_load_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_free) |=> out_valid_reg && wp_reg == $past(wp_reg) + 1'b1)
        else $error("result load without pointer advance");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && !out_free) |=> state_reg == S_OUT && $stable(wp_reg))
        else $error("result dropped while output word pending");

endmodule
